// ===== rtl/ogb_pkg.sv =====
`default_nettype none
package ogb_pkg;

    localparam int MAX_COLUMNS_DEF = 256;
    localparam int MAX_ROWS_DEF    = 256;

    localparam int WORD_W = 64;
    localparam int BIT_W  = 6;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int GRID_W      = 9;

    localparam logic [CFG_INDEX_W-1:0] REG_X_LOW  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_X_HIGH = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_Y_LOW  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_Y_HIGH = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_INV    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_COLS   = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_ROWS   = 3'd6;

    localparam logic signed [31:0] RST_X_LOW  = -32'sd8388608;
    localparam logic signed [31:0] RST_X_HIGH = 32'sd8388608;
    localparam logic signed [31:0] RST_Y_LOW  = -32'sd8388608;
    localparam logic signed [31:0] RST_Y_HIGH = 32'sd8388608;
    localparam logic [31:0]        RST_INV    = 32'd65536;
    localparam logic [GRID_W-1:0]  RST_COLS   = 9'd256;
    localparam logic [GRID_W-1:0]  RST_ROWS   = 9'd256;

    localparam logic [1:0] REQ_CLEAR = 2'd0;
    localparam logic [1:0] REQ_MARK  = 2'd1;
    localparam logic [1:0] REQ_QUERY = 2'd2;

    typedef enum logic [2:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_LOCATE,
        ST_READ,
        ST_REPLY
    } t_state;

    typedef struct packed {
        logic valid;
        logic hit;
    } t_loc;

endpackage
`default_nettype wire

// ===== rtl/ogb_ram.sv =====
`default_nettype none
module ogb_ram #(
    parameter int WIDTH  = 64,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== rtl/ogb_locate.sv =====
`default_nettype none
module ogb_locate #(
    parameter int MAX_COLUMNS = ogb_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_ROWS    = ogb_pkg::MAX_ROWS_DEF,
    parameter int ADDR_W      = 16
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_start,
    input  wire logic signed [31:0]              i_point_x,
    input  wire logic signed [31:0]              i_point_y,
    input  wire logic signed [31:0]              i_x_low,
    input  wire logic signed [31:0]              i_x_high,
    input  wire logic signed [31:0]              i_y_low,
    input  wire logic signed [31:0]              i_y_high,
    input  wire logic        [31:0]              i_inv,
    input  wire logic [ogb_pkg::GRID_W-1:0]      i_cols,
    input  wire logic [ogb_pkg::GRID_W-1:0]      i_rows,
    output ogb_pkg::t_loc                        o_loc,
    output logic             [ADDR_W-1:0]        o_addr
);

    localparam int COL_W  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COLS_W = $clog2(MAX_COLUMNS + 1);
    localparam int ROWS_W = $clog2(MAX_ROWS + 1);
    localparam int PROD_W = ROW_W + COLS_W;

    logic [COLS_W-1:0] cols_lim;
    logic [ROWS_W-1:0] rows_lim;

    logic [3:0]        r_valid;
    logic              r_inwin1;
    logic [31:0]       r_dx;
    logic [31:0]       r_dy;
    logic              r_inwin2;
    logic [31:0]       r_colf;
    logic [31:0]       r_rowf;
    logic              r_hit3;
    logic [COL_W-1:0]  r_col;
    logic [ROW_W-1:0]  r_row;
    logic              r_hit4;
    logic [ADDR_W-1:0] r_addr;

    logic              n_inwin;
    logic [63:0]       n_prodx;
    logic [63:0]       n_prody;
    logic [PROD_W-1:0] n_lin;

    always_comb begin
        cols_lim = (32'(i_cols) < 32'(MAX_COLUMNS)) ? COLS_W'(i_cols) : COLS_W'(MAX_COLUMNS);
        rows_lim = (32'(i_rows) < 32'(MAX_ROWS)) ? ROWS_W'(i_rows) : ROWS_W'(MAX_ROWS);
        n_inwin  = (i_point_x >= i_x_low) && (i_point_x < i_x_high) &&
                   (i_point_y >= i_y_low) && (i_point_y < i_y_high);
        n_prodx  = 64'(r_dx) * 64'(i_inv);
        n_prody  = 64'(r_dy) * 64'(i_inv);
        n_lin    = PROD_W'(r_row) * PROD_W'(cols_lim) + PROD_W'(r_col);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= {r_valid[2:0], i_start};
        end
    end

    always_ff @(posedge i_clk) begin
        r_inwin1 <= n_inwin;
        r_dx     <= 32'(i_point_x - i_x_low);
        r_dy     <= 32'(i_point_y - i_y_low);
        r_inwin2 <= r_inwin1;
        r_colf   <= n_prodx[63:32];
        r_rowf   <= n_prody[63:32];
        r_hit3   <= r_inwin2 && (r_colf < 32'(cols_lim)) && (r_rowf < 32'(rows_lim));
        r_col    <= COL_W'(r_colf);
        r_row    <= ROW_W'(r_rowf);
        r_hit4   <= r_hit3;
        r_addr   <= ADDR_W'(n_lin);
    end

    assign o_loc.valid = r_valid[3];
    assign o_loc.hit   = r_hit4;
    assign o_addr      = r_addr;

endmodule
`default_nettype wire

// ===== rtl/occupancy_grid_bitmap_top.sv =====
// Channel  Direction  Handshake                        Payload
// s_axis   in         i_s_axis_tvalid/o_s_axis_tready  tdata: point_x, point_y; tuser: req_type
// m_axis   out        o_m_axis_tvalid/i_m_axis_tready  tdata: occupied
// cfg      in         i_cfg_valid/o_cfg_ready          i_cfg_index, i_cfg_data
//
// A request is taken only in the idle cycle. A query on the grid passes from the taking cycle
// through the locate pipeline (window check, Q16.16 multiply, range check, row times columns),
// the bitmap read and the loading of the reply back to idle. A mark on the grid ends with the
// bitmap read, its write-back sharing the read cycle; a mark off the grid returns to idle from
// the locate pipeline and a query off the grid goes to the reply. A clear, and the release of
// reset, sweep one bitmap word a cycle over all ceil(MAX_ROWS*MAX_COLUMNS/64) words (1024 by
// default); no request is taken meanwhile. A reply waits in the output register while a new
// request is taken; a later reply holds until it drains.
`default_nettype none
module occupancy_grid_bitmap_top #(
    parameter int MAX_COLUMNS = ogb_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_ROWS    = ogb_pkg::MAX_ROWS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_s_axis_tvalid,
    output logic                                     o_s_axis_tready,
    input  wire logic [63:0]                         i_s_axis_tdata,  // point_x, point_y
    input  wire logic [1:0]                          i_s_axis_tuser,  // req_type
    output logic                                     o_m_axis_tvalid,
    input  wire logic                                i_m_axis_tready,
    output logic [7:0]                               o_m_axis_tdata,  // occupied, zero pad
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [ogb_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  wire logic [ogb_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int CELLS   = MAX_ROWS * MAX_COLUMNS;
    localparam int BIT_W   = ogb_pkg::BIT_W;
    localparam int WORD_W  = ogb_pkg::WORD_W;
    localparam int ADDR_W  = ($clog2(CELLS) > BIT_W) ? $clog2(CELLS) : BIT_W + 1;
    localparam int WADDR_W = ADDR_W - BIT_W;
    localparam int DEPTH   = (CELLS + WORD_W - 1) / WORD_W;
    localparam logic [WADDR_W-1:0] SWEEP_LAST = WADDR_W'(DEPTH - 1);

    ogb_pkg::t_state r_state;
    ogb_pkg::t_state n_state;

    logic signed [31:0]             r_x_low;
    logic signed [31:0]             r_x_high;
    logic signed [31:0]             r_y_low;
    logic signed [31:0]             r_y_high;
    logic [31:0]                    r_inv;
    logic [ogb_pkg::GRID_W-1:0]     r_cols;
    logic [ogb_pkg::GRID_W-1:0]     r_rows;

    logic [WADDR_W-1:0] r_sweep;
    logic               r_is_query;
    logic [WADDR_W-1:0] r_word;
    logic [BIT_W-1:0]   r_bitsel;
    logic               r_bit;
    logic               r_out_valid;
    logic               r_out_occ;

    logic               s_accept;
    logic               cfg_accept;
    logic               loc_start;
    ogb_pkg::t_loc      loc;
    logic [ADDR_W-1:0]  loc_addr;

    logic               ram_we;
    logic [WADDR_W-1:0] ram_waddr;
    logic [WORD_W-1:0]  ram_wdata;
    logic [WORD_W-1:0]  ram_rdata;
    logic               load_out;
    logic               rd_bit;

    assign s_accept   = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready = 1'b1;
    assign cfg_accept = i_cfg_valid && o_cfg_ready;
    assign loc_start  = s_accept &&
                        (i_s_axis_tuser == ogb_pkg::REQ_MARK ||
                         i_s_axis_tuser == ogb_pkg::REQ_QUERY);
    assign rd_bit     = ram_rdata[r_bitsel];

    ogb_locate #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS),
        .ADDR_W      (ADDR_W)
    ) u_locate (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (loc_start),
        .i_point_x (i_s_axis_tdata[31:0]),
        .i_point_y (i_s_axis_tdata[63:32]),
        .i_x_low   (r_x_low),
        .i_x_high  (r_x_high),
        .i_y_low   (r_y_low),
        .i_y_high  (r_y_high),
        .i_inv     (r_inv),
        .i_cols    (r_cols),
        .i_rows    (r_rows),
        .o_loc     (loc),
        .o_addr    (loc_addr)
    );

    ogb_ram #(
        .WIDTH  (WORD_W),
        .DEPTH  (DEPTH),
        .ADDR_W (WADDR_W)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (loc_addr[ADDR_W-1:BIT_W]),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ogb_pkg::ST_SWEEP: begin
                if (r_sweep == SWEEP_LAST) begin
                    n_state = ogb_pkg::ST_IDLE;
                end
            end
            ogb_pkg::ST_IDLE: begin
                if (s_accept) begin
                    case (i_s_axis_tuser)
                        ogb_pkg::REQ_CLEAR: n_state = ogb_pkg::ST_SWEEP;
                        ogb_pkg::REQ_MARK:  n_state = ogb_pkg::ST_LOCATE;
                        ogb_pkg::REQ_QUERY: n_state = ogb_pkg::ST_LOCATE;
                        default:            n_state = ogb_pkg::ST_IDLE;
                    endcase
                end
            end
            ogb_pkg::ST_LOCATE: begin
                if (loc.valid) begin
                    if (loc.hit) begin
                        n_state = ogb_pkg::ST_READ;
                    end else if (r_is_query) begin
                        n_state = ogb_pkg::ST_REPLY;
                    end else begin
                        n_state = ogb_pkg::ST_IDLE;
                    end
                end
            end
            ogb_pkg::ST_READ: begin
                n_state = r_is_query ? ogb_pkg::ST_REPLY : ogb_pkg::ST_IDLE;
            end
            ogb_pkg::ST_REPLY: begin
                if (load_out) begin
                    n_state = ogb_pkg::ST_IDLE;
                end
            end
            default: n_state = ogb_pkg::ST_SWEEP;
        endcase
    end

    always_comb begin
        o_s_axis_tready = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = r_word;
        ram_wdata       = ram_rdata | (WORD_W'(1) << r_bitsel);
        load_out        = 1'b0;
        case (r_state)
            ogb_pkg::ST_SWEEP: begin
                ram_we    = 1'b1;
                ram_waddr = r_sweep;
                ram_wdata = '0;
            end
            ogb_pkg::ST_IDLE: begin
                o_s_axis_tready = 1'b1;
            end
            ogb_pkg::ST_READ: begin
                ram_we = !r_is_query;
            end
            ogb_pkg::ST_REPLY: begin
                load_out = !r_out_valid || i_m_axis_tready;
            end
            default: begin
                o_s_axis_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ogb_pkg::ST_SWEEP;
            r_sweep     <= '0;
            r_out_valid <= 1'b0;
            r_x_low     <= ogb_pkg::RST_X_LOW;
            r_x_high    <= ogb_pkg::RST_X_HIGH;
            r_y_low     <= ogb_pkg::RST_Y_LOW;
            r_y_high    <= ogb_pkg::RST_Y_HIGH;
            r_inv       <= ogb_pkg::RST_INV;
            r_cols      <= ogb_pkg::RST_COLS;
            r_rows      <= ogb_pkg::RST_ROWS;
        end else begin
            r_state <= n_state;
            r_sweep <= (r_state == ogb_pkg::ST_SWEEP) ? r_sweep + WADDR_W'(1) : '0;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (cfg_accept) begin
                case (i_cfg_index)
                    ogb_pkg::REG_X_LOW:  r_x_low  <= i_cfg_data;
                    ogb_pkg::REG_X_HIGH: r_x_high <= i_cfg_data;
                    ogb_pkg::REG_Y_LOW:  r_y_low  <= i_cfg_data;
                    ogb_pkg::REG_Y_HIGH: r_y_high <= i_cfg_data;
                    ogb_pkg::REG_INV:    r_inv    <= i_cfg_data;
                    ogb_pkg::REG_COLS:   r_cols   <= i_cfg_data[ogb_pkg::GRID_W-1:0];
                    ogb_pkg::REG_ROWS:   r_rows   <= i_cfg_data[ogb_pkg::GRID_W-1:0];
                    default:             r_inv    <= r_inv;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_is_query <= (i_s_axis_tuser == ogb_pkg::REQ_QUERY);
        end
        if (r_state == ogb_pkg::ST_LOCATE && loc.valid) begin
            r_word   <= loc_addr[ADDR_W-1:BIT_W];
            r_bitsel <= loc_addr[BIT_W-1:0];
            r_bit    <= 1'b0;
        end else if (r_state == ogb_pkg::ST_READ) begin
            r_bit <= rd_bit;
        end
        if (load_out) begin
            r_out_occ <= r_bit;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {7'b0, r_out_occ};

`ifndef SYNTHESIS
    a_loc_in_locate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        loc.valid |-> (r_state == ogb_pkg::ST_LOCATE))
        else $error("locate result outside locate state");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ogb_pkg::ST_IDLE || r_state == ogb_pkg::ST_LOCATE) |-> !ram_we)
        else $error("bitmap written while not sweeping or marking");

    a_sweep_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ogb_pkg::ST_SWEEP && r_sweep != SWEEP_LAST) |=>
        (r_state == ogb_pkg::ST_SWEEP))
        else $error("sweep left early");
`endif

endmodule
`default_nettype wire
